// ===== hdl/lruc_pkg.sv =====
// Shared constants for the eight-entry LRU cache.
`default_nettype none

package lruc_pkg;

  localparam int unsigned ENTRIES_DEF      = 8;
  localparam int unsigned TAG_BITS_DEF     = 64;
  localparam int unsigned PAYLOAD_BITS_DEF = 32;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

endpackage

`default_nettype wire

// ===== hdl/lruc_match.sv =====
// Parallel tag compare with a lowest-index priority encoder.
`default_nettype none

module lruc_match #(
  parameter int unsigned ENTRIES  = lruc_pkg::ENTRIES_DEF,
  parameter int unsigned TAG_BITS = lruc_pkg::TAG_BITS_DEF
) (
  input  logic [ENTRIES-1:0]                entry_valid,
  input  logic [ENTRIES-1:0][TAG_BITS-1:0]  entry_tag,
  input  logic [TAG_BITS-1:0]               key_tag,
  output logic                              found,
  output logic [$clog2(ENTRIES)-1:0]        found_idx
);
  import lruc_pkg::*;

  localparam int unsigned IDX_W = $clog2(ENTRIES);

  logic [ENTRIES-1:0] match_vec;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_vec[i] = entry_valid[i] && (entry_tag[i] == key_tag);
    end
  end

  // Scan from the top so the lowest matching index wins.
  always_comb begin
    found_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        found_idx = IDX_W'(i);
      end
    end
  end

  assign found = |match_vec;

endmodule

`default_nettype wire

// ===== hdl/lruc_rank.sv =====
// Recency ranks per entry: touch-to-front update and victim select.
`default_nettype none

module lruc_rank #(
  parameter int unsigned ENTRIES = lruc_pkg::ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        touch_en,
  input  logic [$clog2(ENTRIES)-1:0]  touch_idx,
  output logic [$clog2(ENTRIES)-1:0]  victim_idx
);
  import lruc_pkg::*;

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] RANK_LAST = IDX_W'(ENTRIES - 1);

  logic [ENTRIES-1:0][IDX_W-1:0] rank_r;
  logic [ENTRIES-1:0][IDX_W-1:0] rank_nxt;
  logic [ENTRIES-1:0]            last_vec;
  logic [IDX_W-1:0]              old_rank;

  assign old_rank = rank_r[touch_idx];

  always_comb begin
    victim_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      last_vec[i] = (rank_r[i] == RANK_LAST);
      if (last_vec[i]) begin
        victim_idx = IDX_W'(i);
      end
    end
  end

  // Move the touched entry to the front; everything ahead of it drops one place.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (IDX_W'(i) == touch_idx) begin
        rank_nxt[i] = '0;
      end else if (rank_r[i] < old_rank) begin
        rank_nxt[i] = rank_r[i] + 1'b1;
      end else begin
        rank_nxt[i] = rank_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= IDX_W'(i);
      end
    end else if (touch_en) begin
      rank_r <= rank_nxt;
    end
  end

  a_one_victim: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(last_vec))
    else $error("recency ranks lost their permutation");

  a_touch_front: assert property (@(posedge clk) disable iff (!rst_n)
    touch_en |=> rank_r[$past(touch_idx)] == '0)
    else $error("touched entry did not become most recent");

endmodule

`default_nettype wire

// ===== hdl/lru_cache_eight_entry.sv =====
// Top level of the fully associative LRU cache.
//
// Fully associative cache with ENTRIES slots and least-recently-used
// replacement. Each transaction is a lookup or an insert keyed by a tag
// digest, and each one yields exactly one result. The block takes one
// transaction per clock when the result side does not stall. A transaction
// is loaded into the input register at acceptance, and its result is loaded
// into the result register as soon as that register is empty or not stalled.
// While a result waits under stall, one more transaction can sit in the
// input register; after that the input stalls. The tag compare over all
// slots, the rank update and the slot write happen in one pass between
// those registers, so a transaction sees every update made by the one
// before it. No clearing pass is needed after reset.
`default_nettype none

module lru_cache_eight_entry #(
  parameter int unsigned ENTRIES      = lruc_pkg::ENTRIES_DEF,
  parameter int unsigned TAG_BITS     = lruc_pkg::TAG_BITS_DEF,
  parameter int unsigned PAYLOAD_BITS = lruc_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_operation,
  input  logic [TAG_BITS-1:0]     in_key_tag,
  input  logic [PAYLOAD_BITS-1:0] in_payload_in,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_hit,
  output logic [PAYLOAD_BITS-1:0] out_payload_out
);
  import lruc_pkg::*;

  localparam int unsigned IDX_W = $clog2(ENTRIES);

  // Input register
  logic                    s1_valid_r;
  logic                    s1_op_r;
  logic [TAG_BITS-1:0]     s1_tag_r;
  logic [PAYLOAD_BITS-1:0] s1_pay_r;

  // Result register
  logic                    out_valid_r;
  logic                    out_hit_r;
  logic [PAYLOAD_BITS-1:0] out_payload_r;

  // Entry store
  logic [ENTRIES-1:0]                    entry_valid_r;
  logic [ENTRIES-1:0][TAG_BITS-1:0]      entry_tag_r;
  logic [ENTRIES-1:0][PAYLOAD_BITS-1:0]  entry_payload_r;

  logic             advance;
  logic             s1_fire;
  logic             found;
  logic [IDX_W-1:0] found_idx;
  logic [IDX_W-1:0] victim_idx;
  logic [IDX_W-1:0] touch_idx;
  logic             touch_en;
  logic             is_insert;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign s1_fire  = s1_valid_r && advance;

  assign is_insert = (s1_op_r == OP_INSERT);
  assign touch_idx = found ? found_idx : victim_idx;
  assign touch_en  = s1_fire && (found || is_insert);

  lruc_match #(
    .ENTRIES  (ENTRIES),
    .TAG_BITS (TAG_BITS)
  ) u_match (
    .entry_valid (entry_valid_r),
    .entry_tag   (entry_tag_r),
    .key_tag     (s1_tag_r),
    .found       (found),
    .found_idx   (found_idx)
  );

  lruc_rank #(
    .ENTRIES (ENTRIES)
  ) u_rank (
    .clk        (clk),
    .rst_n      (rst_n),
    .touch_en   (touch_en),
    .touch_idx  (touch_idx),
    .victim_idx (victim_idx)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_op_r  <= in_operation;
      s1_tag_r <= in_key_tag;
      s1_pay_r <= in_payload_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  // Payload is returned only on a lookup hit.
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_hit_r <= found;
      if (found && !is_insert) begin
        out_payload_r <= entry_payload_r[found_idx];
      end else begin
        out_payload_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_valid_r <= '0;
    end else if (s1_fire && is_insert) begin
      entry_valid_r[touch_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && is_insert) begin
      entry_tag_r[touch_idx]     <= s1_tag_r;
      entry_payload_r[touch_idx] <= s1_pay_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_payload_out = out_payload_r;

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_hit_r |-> out_payload_r == '0)
    else $error("miss result carries a nonzero payload");

  a_insert_valid: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && is_insert |=> entry_valid_r[$past(touch_idx)])
    else $error("inserted entry not marked valid");

endmodule

`default_nettype wire

// ===== dv/lru_cache_eight_entry_test.sv =====
// Self-checking testbench for the eight-entry LRU cache with random traffic and backpressure.
`timescale 1ns / 100ps

module lru_cache_eight_entry_test;
  import lruc_pkg::*;

  localparam int ENTRIES = ENTRIES_DEF;
  localparam int TAG_W   = TAG_BITS_DEF;
  localparam int PAY_W   = PAYLOAD_BITS_DEF;
  localparam int IDLE_LIMIT = 2000;

  typedef logic [TAG_W-1:0] tag_t;
  typedef logic [PAY_W-1:0] pay_t;

  typedef struct packed {
    logic hit;
    pay_t payload;
  } cache_result_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_operation;
  tag_t in_key_tag;
  pay_t in_payload_in;
  logic out_valid;
  logic out_stall;
  logic out_hit;
  pay_t out_payload_out;

  // Shadow copy of the cache contents and recency order
  logic line_valid [ENTRIES];
  tag_t line_tag [ENTRIES];
  pay_t line_payload [ENTRIES];
  int   line_rank [ENTRIES];

  cache_result_t results_due [$];
  cache_result_t oldest_due;
  int mismatch_count;
  int idle_count;

  int tx_idle_pct;
  int stall_pct;
  int long_hold_req;
  int hold_left;
  int stall_left;

  tag_t key_pool [16];
  int   pool_size;

  lru_cache_eight_entry dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_key_tag     (in_key_tag),
    .in_payload_in  (in_payload_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_payload_out(out_payload_out)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic tag_t pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 80) return key_pool[$urandom_range(pool_size - 1)];
    // near miss: one bit off a live key
    if (r < 90) begin
      return key_pool[$urandom_range(pool_size - 1)] ^
             (tag_t'(1) << $urandom_range(TAG_W - 1));
    end
    return {$urandom, $urandom};
  endfunction

  task automatic promote_line(input int slot);
    int old;
    old = line_rank[slot];
    for (int i = 0; i < ENTRIES; i++) begin
      if (line_rank[i] < old) line_rank[i] = line_rank[i] + 1;
    end
    line_rank[slot] = 0;
  endtask

  task automatic predict_access(input logic op, input tag_t key, input pay_t pay,
                                output cache_result_t res);
    int found;
    int victim;
    found = -1;
    victim = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (found < 0 && line_valid[i] && line_tag[i] == key) found = i;
      if (line_rank[i] == ENTRIES - 1) victim = i;
    end
    res.hit = (found >= 0);
    res.payload = '0;
    if (op == OP_LOOKUP) begin
      if (found >= 0) begin
        res.payload = line_payload[found];
        promote_line(found);
      end
    end else if (found >= 0) begin
      line_payload[found] = pay;
      promote_line(found);
    end else begin
      line_valid[victim] = 1'b1;
      line_tag[victim] = key;
      line_payload[victim] = pay;
      promote_line(victim);
    end
  endtask

  // Valid stays high after acceptance; a gap or a drain lowers it
  task automatic send_item(input logic op, input tag_t key, input pay_t pay);
    cache_result_t res;
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_operation <= op;
    in_key_tag <= key;
    in_payload_in <= pay;
    do @(posedge clk); while (in_stall);
    predict_access(op, key, pay, res);
    results_due.push_back(res);
    if ($urandom_range(99) < tx_idle_pct) begin
      gap = pick_gap();
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_misses();
    send_item(OP_LOOKUP, '0, '1);
    send_item(OP_LOOKUP, '1, '0);
  endtask

  task automatic test_fill_and_evict();
    send_item(OP_INSERT, '1, '1);
    send_item(OP_INSERT, '0, '0);
    send_item(OP_INSERT, {1'b1, {(TAG_W - 2){1'b0}}, 1'b1}, 32'h8000_0001);
    send_item(OP_INSERT, tag_t'(1), pay_t'(1));
    for (int i = 0; i < 4; i++) send_item(OP_INSERT, {$urandom, $urandom}, $urandom);
    // touch the oldest so the next-oldest gets evicted
    send_item(OP_LOOKUP, '1, $urandom);
    send_item(OP_INSERT, 64'h0123_4567_89AB_CDEF, 32'h5A5A_A5A5);
    send_item(OP_LOOKUP, '0, $urandom);
    send_item(OP_LOOKUP, tag_t'(2), $urandom);
  endtask

  task automatic test_update_in_place();
    send_item(OP_INSERT, '1, 32'h1234_5678);
    send_item(OP_LOOKUP, '1, $urandom);
    // a miss on a full cache must not disturb the victim choice
    send_item(OP_LOOKUP, 64'hDEAD_BEEF_0000_0000, $urandom);
    send_item(OP_INSERT, 64'hDEAD_BEEF_0000_0000, '1);
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    stall_pct = 0;
    pool_size = 10;
    for (int k = 0; k < 16; k++) key_pool[k] = {$urandom, $urandom};
    long_hold_req = 150;
    for (int i = 0; i < 30; i++) send_item(1'($urandom_range(1)), pick_key(), $urandom);
    wait_for_results();
    for (int i = 0; i < 10; i++) send_item(1'($urandom_range(1)), pick_key(), $urandom);
  endtask

  task automatic test_random_traffic();
    for (int n = 0; n < 600; n++) begin
      if (n % 75 == 0) begin
        case ($urandom_range(2))
          0: tx_idle_pct = 0;
          1: tx_idle_pct = 15;
          default: tx_idle_pct = 40;
        endcase
        case ($urandom_range(2))
          0: stall_pct = 0;
          1: stall_pct = 15;
          default: stall_pct = 40;
        endcase
        pool_size = $urandom_range(5, 14);
        if ($urandom_range(1) == 1) begin
          for (int k = 0; k < 16; k++) key_pool[k] = {$urandom, $urandom};
        end
      end
      send_item(($urandom_range(99) < 40) ? OP_INSERT : OP_LOOKUP, pick_key(), $urandom);
    end
  endtask

  // Result side: random short stalls plus the requested long hold-off
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req != 0) begin
        hold_left = long_hold_req;
        long_hold_req = 0;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(99) < stall_pct) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected transaction: expected none, got hit %0b payload %h",
                 $time, out_hit, out_payload_out);
        mismatch_count++;
      end else begin
        oldest_due = results_due.pop_front();
        if (out_hit !== oldest_due.hit) begin
          $display("%0t: hit: expected %0b, got %0b", $time, oldest_due.hit, out_hit);
          mismatch_count++;
        end
        if (out_payload_out !== oldest_due.payload) begin
          $display("%0t: payload_out: expected %h, got %h",
                   $time, oldest_due.payload, out_payload_out);
          mismatch_count++;
        end
      end
    end
  end

  // Abort when no transaction moves on either side for too long
  initial begin
    idle_count = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_count = 0;
      else idle_count++;
      if (idle_count >= IDLE_LIMIT) begin
        $display("%0t: timeout, %0d results outstanding", $time, results_due.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = OP_LOOKUP;
    in_key_tag = '0;
    in_payload_in = '0;
    mismatch_count = 0;
    tx_idle_pct = 20;
    stall_pct = 20;
    long_hold_req = 0;
    pool_size = 8;
    for (int i = 0; i < ENTRIES; i++) begin
      line_valid[i] = 1'b0;
      line_tag[i] = '0;
      line_payload[i] = '0;
      line_rank[i] = i;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_misses();
    test_fill_and_evict();
    test_update_in_place();
    test_backpressure();
    test_random_traffic();

    wait_for_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/lruc_pkg.sv
hdl/lruc_match.sv
hdl/lruc_rank.sv
hdl/lru_cache_eight_entry.sv
dv/lru_cache_eight_entry_test.sv
